/* design/assert_macros.svh */
// Assertion helpers shared by the RTL; the using module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define HTFP_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define HTFP_CHK_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/htfp_pkg.sv */
`default_nettype none
package htfp_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int SLOT_W        = $clog2(TABLE_DEPTH);
  localparam int CAP_W         = SLOT_W + 1;
  localparam int MAX_KEY_BYTES = 32;
  localparam int KEY_WORDS     = MAX_KEY_BYTES / 8;
  localparam int KW_W          = $clog2(KEY_WORDS);
  localparam int WORD_W        = 64;
  localparam int HASH_W        = 64;
  localparam int MARK_W        = 8;
  localparam int LEN_W         = 6;
  localparam int TSL_W         = 4;
  localparam logic [TSL_W-1:0] TSL_RESET = TSL_W'(SLOT_W);
  localparam logic [TSL_W-1:0] TSL_MIN   = TSL_W'(1);
  localparam logic [TSL_W-1:0] TSL_MAX   = TSL_W'(SLOT_W);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_KEY_BYTES);

  // Input tdata layout, lowest bit first
  localparam int SLOT_LSB = 0;
  localparam int MARK_LSB = SLOT_LSB + SLOT_W;
  localparam int HASH_LSB = MARK_LSB + MARK_W;
  localparam int LEN_LSB  = HASH_LSB + HASH_W;
  localparam int KEY_LSB  = LEN_LSB + LEN_W;
  localparam int IN_BITS  = KEY_LSB + KEY_WORDS * WORD_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SLOT_W + 7) / 8) * 8;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_ISSUE,
    ST_CMP,
    ST_KEY,
    ST_DONE
  } state_t;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [MARK_W-1:0] ctrl;
    logic [HASH_W-1:0] hash;
    logic [LEN_W-1:0]  len;
    key_t              key;
  } slot_wr_t;

  typedef struct packed {
    logic [MARK_W-1:0] ctrl;
    logic [HASH_W-1:0] hash;
    logic [LEN_W-1:0]  len;
    key_t              key;
  } slot_rd_t;

  // Byte lanes of key word kw that lie below len
  function automatic logic [WORD_W-1:0] byte_mask(input logic [KW_W-1:0] kw,
                                                   input logic [LEN_W-1:0] len);
    logic [WORD_W-1:0] m;
    logic [LEN_W:0]    pos;
    m = '0;
    for (int b = 0; b < WORD_W / 8; b++) begin
      pos = (LEN_W + 1)'(kw) * (LEN_W + 1)'(WORD_W / 8) + (LEN_W + 1)'(b);
      m[b*8 +: 8] = (pos < {1'b0, len}) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

/* design/hash_table_fingerprint_probe_unit.sv */
// Channel  Ports                        Payload
// in       in_tvalid/in_tready          tuser: operation; tdata: slot..key_word3
// out      out_tvalid/out_tready        tuser: found; tdata: found_slot
// cfg      cfg_wr_en/cfg_wr_data        table_size_log2
//
// Write: accept, store write, result. Lookup: per probed slot a memory read, then a hash
// compare, plus a compare of up to 4 key words on a fingerprint/hash hit, all through
// one 64-bit compare unit.
// After reset all 1024 slots of the control store are cleared with in_tready low.
// A finished result waits in the output register; the next item may be accepted
// meanwhile but its result stalls until out_tready takes the previous one.
`default_nettype none
module hash_table_fingerprint_probe_unit
  import htfp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // slot_index, marker, hash, key_length,
                                                  // key_word0..key_word3
  input  wire logic                   in_tuser,   // operation
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // found_slot
  output logic                        out_tuser,  // found
  input  wire logic                   cfg_wr_en,
  input  wire logic [TSL_W-1:0]       cfg_wr_data // table_size_log2
);

`include "assert_macros.svh"

  state_t            state_r, state_nxt;
  logic [TSL_W-1:0]  tsl_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CAP_W-1:0]  probe_r, probe_nxt;
  logic [KW_W-1:0]   kw_r, kw_nxt;
  logic              found_r, found_nxt;
  logic              out_valid_r;
  logic              out_found_r;
  logic [SLOT_W-1:0] out_slot_r;

  op_t               op_r;
  logic [MARK_W-1:0] mark_r;
  logic [HASH_W-1:0] hash_r;
  logic [LEN_W-1:0]  len_r;
  key_t              key_r;

  logic [TSL_W-1:0]  lg_c;
  logic [CAP_W-1:0]  cap_c;
  logic [SLOT_W-1:0] mask_c;
  logic              accept, out_free, last_probe;
  op_t               in_op;
  logic [LEN_W-1:0]  in_len;
  logic [HASH_W-1:0] in_hash;

  slot_wr_t          wr;
  slot_rd_t          rd;
  logic              rd_en;

  logic [WORD_W-1:0] cmp_a, cmp_b, cmp_m;
  logic              cmp_eq, head_ok, slot_empty;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign in_op      = op_t'(in_tuser);
  assign in_len     = in_tdata[LEN_LSB +: LEN_W];
  assign in_hash    = in_tdata[HASH_LSB +: HASH_W];

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = OUT_TDATA_W'(out_slot_r);

  // Clamp the table size and derive the probe mask
  always_comb begin
    lg_c = tsl_r;
    if (tsl_r < TSL_MIN) lg_c = TSL_MIN;
    if (tsl_r > TSL_MAX) lg_c = TSL_MAX;
    cap_c  = CAP_W'(1) << lg_c;
    mask_c = SLOT_W'(cap_c - CAP_W'(1));
  end

  assign last_probe = (probe_r + CAP_W'(1)) == cap_c;

  // Shared compare unit: full hash in ST_CMP, one masked key word a step in ST_KEY
  always_comb begin
    if (state_r == ST_KEY) begin
      cmp_a = rd.key[kw_r];
      cmp_b = key_r[kw_r];
      cmp_m = byte_mask(kw_r, len_r);
    end else begin
      cmp_a = rd.hash;
      cmp_b = hash_r;
      cmp_m = '1;
    end
    cmp_eq = ((cmp_a ^ cmp_b) & cmp_m) == '0;
  end

  assign slot_empty = (rd.ctrl == '0);
  assign head_ok    = (rd.ctrl == mark_r) && (rd.len == len_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (slot_r == SLOT_W'(TABLE_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_WRITE)   state_nxt = ST_WRITE;
          else if (in_len > LEN_MAX) state_nxt = ST_DONE;
          else                     state_nxt = ST_ISSUE;
        end
      end
      ST_WRITE: state_nxt = ST_DONE;
      ST_ISSUE: state_nxt = ST_CMP;
      ST_CMP: begin
        if (slot_empty)              state_nxt = ST_DONE;
        else if (head_ok && cmp_eq)  state_nxt = ST_KEY;
        else if (last_probe)         state_nxt = ST_DONE;
        else                         state_nxt = ST_ISSUE;
      end
      ST_KEY: begin
        if (cmp_eq) begin
          if (kw_r == KW_W'(KEY_WORDS - 1)) state_nxt = ST_DONE;
        end else if (last_probe) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Datapath controls
  always_comb begin
    slot_nxt  = slot_r;
    probe_nxt = probe_r;
    kw_nxt    = kw_r;
    found_nxt = found_r;
    wr        = '0;
    rd_en     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        wr.en    = 1'b1;
        wr.addr  = slot_r;
        slot_nxt = slot_r + SLOT_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          slot_nxt  = (in_op == OP_WRITE) ? in_tdata[SLOT_LSB +: SLOT_W]
                                          : in_hash[SLOT_W-1:0] & mask_c;
          probe_nxt = '0;
          found_nxt = 1'b0;
        end
      end
      ST_WRITE: begin
        wr.en   = (len_r <= LEN_MAX);
        wr.addr = slot_r;
        wr.ctrl = mark_r;
        wr.hash = hash_r;
        wr.len  = len_r;
        for (int w = 0; w < KEY_WORDS; w++) begin
          wr.key[w] = key_r[w] & byte_mask(KW_W'(w), len_r);
        end
      end
      ST_ISSUE: rd_en = 1'b1;
      ST_CMP: begin
        if (!slot_empty) begin
          if (head_ok && cmp_eq) begin
            kw_nxt = '0;
          end else begin
            probe_nxt = probe_r + CAP_W'(1);
            slot_nxt  = (slot_r + SLOT_W'(1)) & mask_c;
          end
        end
      end
      ST_KEY: begin
        if (!cmp_eq) begin
          probe_nxt = probe_r + CAP_W'(1);
          slot_nxt  = (slot_r + SLOT_W'(1)) & mask_c;
        end else if (kw_r == KW_W'(KEY_WORDS - 1)) begin
          found_nxt = 1'b1;
        end else begin
          kw_nxt = kw_r + KW_W'(1);
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      tsl_r       <= TSL_RESET;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      if (cfg_wr_en) tsl_r <= cfg_wr_data;
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_tready)                out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
    kw_r    <= kw_nxt;
    found_r <= found_nxt;
    if (accept) begin
      op_r   <= in_op;
      mark_r <= in_tdata[MARK_LSB +: MARK_W];
      hash_r <= in_hash;
      len_r  <= in_len;
      for (int w = 0; w < KEY_WORDS; w++) begin
        key_r[w] <= in_tdata[KEY_LSB + w*WORD_W +: WORD_W];
      end
    end
    if (state_r == ST_DONE && out_free) begin
      out_found_r <= found_r && (op_r == OP_LOOKUP);
      out_slot_r  <= found_r ? slot_r : '0;
    end
  end

  htfp_slot_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (slot_r),
    .rd      (rd)
  );

  `HTFP_CHK(a_busy_after_accept, (in_tvalid && in_tready) |=> !in_tready, "accepted while busy")
  `HTFP_CHK(a_probe_bound, (state_r == ST_CMP || state_r == ST_KEY) |-> (probe_r < cap_c), "probe count past capacity")
  `HTFP_CHK(a_done_holds, (state_r == ST_DONE && !out_free) |=> (state_r == ST_DONE && $stable(found_r) && $stable(slot_r)), "stalled result changed")
  `HTFP_CHK(a_key_starts_at_zero, (state_r == ST_CMP && state_nxt == ST_KEY) |=> (kw_r == '0), "key compare not from word zero")

endmodule
`default_nettype wire

/* design/htfp_slot_store.sv */
`default_nettype none
module htfp_slot_store
  import htfp_pkg::*;
(
  input  wire logic              clk,
  input  wire slot_wr_t          wr,
  input  wire logic              rd_en,
  input  wire logic [SLOT_W-1:0] rd_addr,
  output slot_rd_t               rd
);

  logic [MARK_W-1:0] ctrl_mem [TABLE_DEPTH];
  logic [HASH_W-1:0] hash_mem [TABLE_DEPTH];
  logic [LEN_W-1:0]  len_mem  [TABLE_DEPTH];
  key_t              key_mem  [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ctrl_mem[wr.addr] <= wr.ctrl;
      hash_mem[wr.addr] <= wr.hash;
      len_mem[wr.addr]  <= wr.len;
      key_mem[wr.addr]  <= wr.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd.ctrl <= ctrl_mem[rd_addr];
      rd.hash <= hash_mem[rd_addr];
      rd.len  <= len_mem[rd_addr];
      rd.key  <= key_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* tb/hash_table_fingerprint_probe_unit_tb.sv */
`default_nettype none
module hash_table_fingerprint_probe_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import htfp_pkg::*;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [MARK_W-1:0] marker;
    logic [HASH_W-1:0] hash;
    logic [LEN_W-1:0]  len;
    key_t              key;
  } probe_item_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } probe_result_t;

  typedef struct {
    bit               is_cfg;
    logic [TSL_W-1:0] cfg_value;
    probe_item_t      item;
    bit               typed;
    probe_result_t    want;
  } stim_row_t;

  localparam key_t KEY_ONES   = '1;
  localparam key_t KEY_ZERO   = '0;
  localparam key_t KEY_SAMPLE = {64'h0F1E2D3C4B5A6978, 64'h8796A5B4C3D2E1F0,
                                 64'h1122334455667788, 64'hA5C3000000007E81};
  // Same bytes 0..8 as KEY_SAMPLE, everything above differs
  localparam key_t KEY_TAIL   = {64'hF0E1D2C3B4A59687, 64'h7869584736251A0F,
                                 64'hEEDDCCBBAA998888, 64'hA5C3000000007E81};
  localparam key_t KEY_NO_TOP = {64'h00FFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
                                 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF};
  localparam logic [15:0] FIRST_SIZES = {4'd3, 4'd15, 4'd10, 4'd1};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_wr_en = 1'b0;
  logic [TSL_W-1:0]       cfg_wr_data = '0;

  // Shadow of the table and its size register
  logic [MARK_W-1:0] ctrl_mem [TABLE_DEPTH] = '{default: '0};
  logic [HASH_W-1:0] hash_mem [TABLE_DEPTH];
  logic [LEN_W-1:0]  len_mem  [TABLE_DEPTH];
  logic [WORD_W-1:0] key_mem  [TABLE_DEPTH][KEY_WORDS];
  logic [TSL_W-1:0]  table_size = TSL_RESET;

  probe_result_t pending_results[$];
  probe_item_t   stored_keys[$];
  bit            no_idle = 1'b0;
  int            mismatches = 0;
  int            n_writes = 0;
  int            n_lookups = 0;
  int            n_hits = 0;
  int            n_sizes = 0;

  hash_table_fingerprint_probe_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #250_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned table_capacity();
    int unsigned lg;
    lg = table_size;
    if (lg < 1) lg = 1;
    if (lg > SLOT_W) lg = SLOT_W;
    return 1 << lg;
  endfunction

  function automatic logic [WORD_W-1:0] lane_mask(int w, int len);
    int first;
    first = w * 8;
    if (len <= first) return '0;
    if (len - first >= 8) return '1;
    return (64'd1 << ((len - first) * 8)) - 64'd1;
  endfunction

  function automatic bit key_matches(int s, key_t key, int len);
    for (int w = 0; w < KEY_WORDS; w++) begin
      if (((key_mem[s][w] ^ key[w]) & lane_mask(w, len)) != '0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Update the shadow table and return what the block should answer
  function automatic probe_result_t predict_item(probe_item_t it);
    probe_result_t res;
    int unsigned   cap;
    int unsigned   mask;
    int unsigned   s;
    res = '0;
    if (it.len > LEN_MAX) return res;
    if (it.op == OP_WRITE) begin
      ctrl_mem[it.slot] = it.marker;
      hash_mem[it.slot] = it.hash;
      len_mem[it.slot]  = it.len;
      for (int w = 0; w < KEY_WORDS; w++) key_mem[it.slot][w] = it.key[w] & lane_mask(w, it.len);
      return res;
    end
    cap  = table_capacity();
    mask = cap - 1;
    for (int unsigned p = 0; p < cap; p++) begin
      s = (int'(it.hash[SLOT_W-1:0]) + p) & mask;
      if (ctrl_mem[s] == '0) return res;
      if (ctrl_mem[s] == it.marker && hash_mem[s] == it.hash && len_mem[s] == it.len &&
          key_matches(s, it.key, it.len)) begin
        res.found = 1'b1;
        res.slot  = SLOT_W'(s);
        return res;
      end
    end
    return res;
  endfunction

  function automatic stim_row_t item_row(op_t op, logic [SLOT_W-1:0] slot,
                                         logic [MARK_W-1:0] mk, logic [HASH_W-1:0] h,
                                         logic [LEN_W-1:0] len, key_t key, bit typed,
                                         bit ef, logic [SLOT_W-1:0] es);
    stim_row_t row;
    row.is_cfg     = 1'b0;
    row.cfg_value  = '0;
    row.item       = '{op: op, slot: slot, marker: mk, hash: h, len: len, key: key};
    row.typed      = typed;
    row.want.found = ef;
    row.want.slot  = es;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [TSL_W-1:0] v);
    stim_row_t row;
    row           = item_row(OP_WRITE, '0, '0, '0, '0, KEY_ZERO, 1'b0, 1'b0, '0);
    row.is_cfg    = 1'b1;
    row.cfg_value = v;
    return row;
  endfunction

  task automatic send_item(probe_item_t it, bit typed, probe_result_t want);
    int            gap;
    probe_result_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= IN_TDATA_W'({it.key, it.len, it.hash, it.marker, it.slot});
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    pred = predict_item(it);
    pending_results.push_back(typed ? want : pred);
    if (it.op == OP_WRITE) n_writes++;
    else begin
      n_lookups++;
      if (pred.found) n_hits++;
    end
  endtask

  // Drain the block, then change the table size
  task automatic write_table_size(logic [TSL_W-1:0] v);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    table_size = v;
    n_sizes++;
  endtask

  initial begin : result_sink
    int            stall;
    probe_result_t want;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction: expected none, actual found=%0b slot=%0d",
                 $realtime, out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.found) begin
          $display("%0t: found mismatch: expected %0b, actual %0b",
                   $realtime, want.found, out_tuser);
          mismatches++;
        end
        if (out_tdata !== OUT_TDATA_W'(want.slot)) begin
          $display("%0t: found_slot mismatch: expected %0d, actual %0d",
                   $realtime, want.slot, out_tdata);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t   directed[$];
    probe_item_t it;
    int          r;
    int          b;
    int unsigned cap;
    int unsigned occ;
    int unsigned lim;
    int unsigned s;
    bit          placed;

    // After reset, extremes of every field, wrap-around, deletion, long keys
    directed.push_back(item_row(OP_LOOKUP, '0, 8'h5A, '0, 6'd0, KEY_ZERO, 1, 0, '0));
    directed.push_back(item_row(OP_WRITE, '1, 8'hFF, '1, 6'd32, KEY_ONES, 1, 0, '0));
    directed.push_back(item_row(OP_LOOKUP, '0, 8'hFF, '1, 6'd32, KEY_ONES, 1, 1, '1));
    directed.push_back(item_row(OP_LOOKUP, '1, 8'hFF, '1, 6'd32, KEY_NO_TOP, 1, 0, '0));
    directed.push_back(item_row(OP_WRITE, '0, 8'h33, 64'h3FF, 6'd8, KEY_SAMPLE, 1, 0, '0));
    directed.push_back(item_row(OP_LOOKUP, 10'd7, 8'h33, 64'h3FF, 6'd8, KEY_TAIL, 0, 0, '0));
    directed.push_back(item_row(OP_LOOKUP, '0, 8'h00, 64'd5, 6'd0, KEY_ZERO, 1, 0, '0));
    directed.push_back(item_row(OP_WRITE, 10'd5, 8'h07, 64'd5, 6'd33, KEY_ONES, 1, 0, '0));
    directed.push_back(item_row(OP_LOOKUP, '0, 8'h07, 64'd5, 6'd0, KEY_ZERO, 0, 0, '0));
    directed.push_back(item_row(OP_LOOKUP, '0, 8'h33, 64'h3FF, 6'h3F, KEY_SAMPLE, 1, 0, '0));
    directed.push_back(item_row(OP_WRITE, '0, 8'h00, 64'h3FF, 6'd8, KEY_SAMPLE, 0, 0, '0));
    directed.push_back(item_row(OP_LOOKUP, '0, 8'h33, 64'h3FF, 6'd8, KEY_SAMPLE, 0, 0, '0));
    directed.push_back(item_row(OP_WRITE, 10'd2, 8'h80, 64'd2, 6'd9, KEY_SAMPLE, 0, 0, '0));
    directed.push_back(item_row(OP_LOOKUP, '0, 8'h80, 64'd2, 6'd9, KEY_TAIL, 0, 0, '0));
    // Size below range: two slots, full pass without a hit, entry outside the table
    directed.push_back(cfg_row(4'd0));
    directed.push_back(item_row(OP_WRITE, '0, 8'h11, 64'd0, 6'd0, KEY_ONES, 0, 0, '0));
    directed.push_back(item_row(OP_WRITE, 10'd1, 8'h12, 64'd1, 6'd0, KEY_ZERO, 0, 0, '0));
    directed.push_back(item_row(OP_LOOKUP, '0, 8'h13, 64'd0, 6'd0, KEY_ZERO, 0, 0, '0));
    directed.push_back(item_row(OP_LOOKUP, '0, 8'h12, 64'd1, 6'd0, KEY_ONES, 0, 0, '0));
    directed.push_back(item_row(OP_LOOKUP, '0, 8'h80, 64'd2, 6'd9, KEY_SAMPLE, 0, 0, '0));
    // Size above range clamps to the full store
    directed.push_back(cfg_row(4'd15));
    directed.push_back(item_row(OP_LOOKUP, '0, 8'h80, 64'd2, 6'd9, KEY_TAIL, 0, 0, '0));
    directed.push_back(item_row(OP_LOOKUP, '0, 8'h12, 64'd1, 6'd0, KEY_ZERO, 0, 0, '0));
    directed.push_back(cfg_row(4'd1));
    directed.push_back(item_row(OP_LOOKUP, '0, 8'h11, 64'd0, 6'd0, KEY_ZERO, 0, 0, '0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_table_size(directed[i].cfg_value);
      else send_item(directed[i].item, directed[i].typed, directed[i].want);
    end

    for (int ph = 0; ph < 12; ph++) begin
      write_table_size(ph < 4 ? FIRST_SIZES[ph*4 +: 4] : TSL_W'($urandom_range(0, 15)));
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 85; n++) begin
        cap       = table_capacity();
        r         = $urandom_range(0, 99);
        it.op     = OP_LOOKUP;
        it.slot   = SLOT_W'($urandom);
        it.marker = MARK_W'($urandom);
        it.hash   = {$urandom, $urandom};
        it.len    = LEN_W'($urandom_range(0, MAX_KEY_BYTES));
        it.key    = {$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
        if (r < 35) begin
          occ = 0;
          for (int unsigned p = 0; p < cap; p++) if (ctrl_mem[p] != '0) occ++;
          lim = (cap <= 16) ? cap : cap / 2;
          it.op = OP_WRITE;
          if (occ < lim) begin
            // Insert at the first free slot of the probe chain
            it.marker = MARK_W'($urandom_range(1, 255));
            placed    = 1'b0;
            for (int unsigned p = 0; p < cap && !placed; p++) begin
              s = (int'(it.hash[SLOT_W-1:0]) + p) & (cap - 1);
              if (ctrl_mem[s] == '0) begin
                it.slot = SLOT_W'(s);
                placed  = 1'b1;
              end
            end
            stored_keys.push_back(it);
            if (stored_keys.size() > 64) void'(stored_keys.pop_front());
          end else begin
            it.marker = '0;
            it.slot   = SLOT_W'($urandom_range(0, cap - 1));
          end
        end else if (r < 70 && stored_keys.size() > 0) begin
          it      = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
          it.op   = OP_LOOKUP;
          it.slot = SLOT_W'($urandom);
          // Spoil one part of the key now and then
          if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
              0: it.marker = it.marker ^ MARK_W'(1 << $urandom_range(0, 7));
              1: begin
                b = $urandom_range(0, HASH_W - 1);
                it.hash[b] = ~it.hash[b];
              end
              2: it.len = (it.len == 0) ? LEN_W'(1) : it.len - LEN_W'(1);
              default: begin
                if (it.len != 0) begin
                  b = $urandom_range(0, it.len * 8 - 1);
                  it.key[b/64][b%64] = ~it.key[b/64][b%64];
                end
              end
            endcase
          end
        end else if (r < 80) begin
          it.op = OP_LOOKUP;
        end else if (r < 88) begin
          it.op = OP_WRITE;
        end else if (r < 93) begin
          it.op  = op_t'($urandom_range(0, 1));
          it.len = LEN_W'($urandom_range(MAX_KEY_BYTES + 1, 63));
        end else begin
          it.op     = OP_WRITE;
          it.marker = '0;
          it.slot   = SLOT_W'($urandom_range(0, cap - 1));
        end
        send_item(it, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    no_idle = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d writes and %0d lookups (%0d hits) across %0d table-size settings,",
             n_writes, n_lookups, n_hits, n_sizes);
    $display("with random stalls on both channels; %0d mismatches.", mismatches);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire

/* hash_table_fingerprint_probe_unit.f */
+incdir+design
design/htfp_pkg.sv
design/htfp_slot_store.sv
design/hash_table_fingerprint_probe_unit.sv
tb/hash_table_fingerprint_probe_unit_tb.sv
